[hw/rtl/mtes_pkg.sv]
package mtes_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 16;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_CANCEL = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ADD_OK  = 2'd0,
    KIND_FIRED   = 2'd1,
    KIND_SUMMARY = 2'd2,
    KIND_FULL    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRE,
    ST_ACT,
    ST_SUM,
    ST_CANCEL
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] delay_ms;
    logic [15:0] period_ms;
    logic [15:0] cancel_id;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] timer_id;
    logic [31:0] next_delay_ms;
    logic        last;
  } out_word_t;

endpackage

[hw/rtl/multi_timer_expiry_scheduler_top.sv]
// Channel   Handshake              Word
// in        start_i / busy_o       in_i  (mtes_pkg::in_word_t)
// result    res_valid_o strobe     res_o (mtes_pkg::out_word_t)
//
// N = TIMER_SLOTS; each scan streams the slot memory through its one read port.
// Add: busy stays low; the result word is out in the cycle after accept.
// Cancel: busy for one scan after accept, no result.
// Tick: busy for fire scan+ACT per due slot (fired, or dropped after cancel)
// and once more, then a summary scan; summary word in the first idle cycle.
// Reset clears time, counters and the pending/armed bits; the slot memory is
// not cleared. Results last one cycle each and cannot be stalled.
module multi_timer_expiry_scheduler_top #(
  parameter int unsigned TIMER_SLOTS = mtes_pkg::TIMER_SLOTS_DEF,
  parameter int unsigned ID_BITS     = mtes_pkg::ID_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  mtes_pkg::in_word_t  in_i,
  output logic                res_valid_o,
  output mtes_pkg::out_word_t res_o
);

  localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef struct packed {
    logic [31:0]        deadline;
    logic [15:0]        period;
    logic [ID_BITS-1:0] ident;
    logic [31:0]        order;
  } entry_t;

  entry_t mem [TIMER_SLOTS];
  entry_t rdata_q, wdata;
  logic   we;
  logic [IW-1:0] waddr, raddr;

  mtes_pkg::state_e state_q, state_d;
  logic [IW:0]   cnt_q, cnt_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [31:0]   now_q, now_d, ins_q, ins_d;
  logic [ID_BITS-1:0] nid_q, nid_d;
  logic [TIMER_SLOTS-1:0] pend_q, pend_d, arm_q, arm_d;
  logic          found_q, found_d, any_q, any_d;
  logic [31:0]   bkey_q, bkey_d, bord_q, bord_d, min_q, min_d;
  logic [IW-1:0] bidx_q, bidx_d;
  logic [ID_BITS-1:0] bid_q, bid_d;
  logic [15:0]   bper_q, bper_d, cid_q, cid_d;
  logic          ov_q, ov_d;
  mtes_pkg::out_word_t out_q, out_d;

  logic          scan_end, accept;
  logic [31:0]   diff, key, odiff;
  logic          due;
  logic          free_ok;
  logic [IW-1:0] free_idx;
  logic [ID_BITS-1:0] new_id;

  assign accept   = start_i && (state_q == mtes_pkg::ST_IDLE);
  assign busy_o   = (state_q != mtes_pkg::ST_IDLE);
  assign scan_end = rd_vld_q && (rd_idx_q == IW'(TIMER_SLOTS - 1));
  assign diff     = rdata_q.deadline - now_q;
  assign key      = diff ^ 32'h8000_0000;
  assign odiff    = rdata_q.order - bord_q;
  assign due      = (diff == 32'd0) || diff[31];
  assign new_id   = ((nid_q + ID_BITS'(1)) == '0) ? ID_BITS'(1) : nid_q + ID_BITS'(1);
  assign res_valid_o = ov_q;
  assign res_o       = out_q;

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!pend_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mtes_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_i.mode)
            mtes_pkg::MODE_TICK:   state_d = mtes_pkg::ST_FIRE;
            mtes_pkg::MODE_CANCEL: state_d = mtes_pkg::ST_CANCEL;
            default:               state_d = mtes_pkg::ST_IDLE;
          endcase
        end
      end
      mtes_pkg::ST_FIRE:   if (scan_end) state_d = mtes_pkg::ST_ACT;
      mtes_pkg::ST_ACT:    state_d = found_q ? mtes_pkg::ST_FIRE : mtes_pkg::ST_SUM;
      mtes_pkg::ST_SUM:    if (scan_end) state_d = mtes_pkg::ST_IDLE;
      mtes_pkg::ST_CANCEL: if (scan_end) state_d = mtes_pkg::ST_IDLE;
      default:             state_d = mtes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;  rd_vld_d = 1'b0;  rd_idx_d = rd_idx_q;
    now_d = now_q;  ins_d = ins_q;  nid_d = nid_q;
    pend_d = pend_q;  arm_d = arm_q;
    found_d = found_q;  any_d = any_q;  bkey_d = bkey_q;  bord_d = bord_q;
    min_d = min_q;  bidx_d = bidx_q;  bid_d = bid_q;  bper_d = bper_q;
    cid_d = cid_q;
    ov_d = 1'b0;  out_d = out_q;
    we = 1'b0;  waddr = free_idx;  wdata = rdata_q;
    raddr = cnt_q[IW-1:0];

    if ((state_q == mtes_pkg::ST_FIRE || state_q == mtes_pkg::ST_SUM ||
         state_q == mtes_pkg::ST_CANCEL) && cnt_q < (IW+1)'(TIMER_SLOTS)) begin
      rd_vld_d = 1'b1;
      rd_idx_d = cnt_q[IW-1:0];
      cnt_d    = cnt_q + (IW+1)'(1);
    end

    case (state_q)
      mtes_pkg::ST_IDLE: begin
        cnt_d   = '0;
        found_d = 1'b0;
        any_d   = 1'b0;
        min_d   = '0;
        if (accept) begin
          cid_d = in_i.cancel_id;
          case (in_i.mode)
            mtes_pkg::MODE_TICK: now_d = now_q + 32'd1;
            mtes_pkg::MODE_ADD: begin
              ov_d = 1'b1;
              out_d.last = 1'b1;
              out_d.next_delay_ms = '0;
              if (free_ok) begin
                we = 1'b1;
                wdata.deadline = now_q + 32'(in_i.delay_ms);
                wdata.period   = in_i.period_ms;
                wdata.ident    = new_id;
                wdata.order    = ins_q;
                ins_d = ins_q + 32'd1;
                nid_d = new_id;
                pend_d[free_idx] = 1'b1;
                arm_d[free_idx]  = 1'b1;
                out_d.kind     = mtes_pkg::KIND_ADD_OK;
                out_d.timer_id = 16'(32'(new_id));
              end else begin
                out_d.kind     = mtes_pkg::KIND_FULL;
                out_d.timer_id = '0;
              end
            end
            default: ;
          endcase
        end
      end
      mtes_pkg::ST_FIRE: begin
        if (rd_vld_q && pend_q[rd_idx_q] && due &&
            (!found_q || key < bkey_q || (key == bkey_q && odiff[31]))) begin
          found_d = 1'b1;
          bkey_d  = key;
          bord_d  = rdata_q.order;
          bidx_d  = rd_idx_q;
          bid_d   = rdata_q.ident;
          bper_d  = rdata_q.period;
        end
      end
      mtes_pkg::ST_ACT: begin
        cnt_d   = '0;
        found_d = 1'b0;
        if (found_q) begin
          if (!arm_q[bidx_q]) begin
            pend_d[bidx_q] = 1'b0;
          end else begin
            ov_d = 1'b1;
            out_d.kind = mtes_pkg::KIND_FIRED;
            out_d.timer_id = 16'(32'(bid_q));
            out_d.next_delay_ms = '0;
            out_d.last = 1'b0;
            if (bper_q != 16'd0) begin
              we = 1'b1;
              waddr = bidx_q;
              wdata.deadline = now_q + 32'(bper_q);
              wdata.period   = bper_q;
              wdata.ident    = bid_q;
              wdata.order    = ins_q;
              ins_d = ins_q + 32'd1;
            end else begin
              pend_d[bidx_q] = 1'b0;
              arm_d[bidx_q]  = 1'b0;
            end
          end
        end
      end
      mtes_pkg::ST_SUM: begin
        if (rd_vld_q && pend_q[rd_idx_q] && (!any_q || diff < min_q)) begin
          min_d = diff;
          any_d = 1'b1;
        end
        if (scan_end) begin
          ov_d = 1'b1;
          out_d.kind = mtes_pkg::KIND_SUMMARY;
          out_d.timer_id = '0;
          out_d.next_delay_ms = min_d;
          out_d.last = 1'b1;
        end
      end
      mtes_pkg::ST_CANCEL: begin
        if (rd_vld_q && pend_q[rd_idx_q] && arm_q[rd_idx_q] &&
            (32'(rdata_q.ident) == 32'(cid_q))) begin
          arm_d[rd_idx_q] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    bkey_q <= bkey_d;  bord_q <= bord_d;  bidx_q <= bidx_d;
    bid_q  <= bid_d;   bper_q <= bper_d;  cid_q  <= cid_d;
    min_q  <= min_d;   out_q  <= out_d;   rd_idx_q <= rd_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mtes_pkg::ST_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      now_q    <= '0;
      ins_q    <= '0;
      nid_q    <= '0;
      pend_q   <= '0;
      arm_q    <= '0;
      found_q  <= 1'b0;
      any_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      now_q    <= now_d;
      ins_q    <= ins_d;
      nid_q    <= nid_d;
      pend_q   <= pend_d;
      arm_q    <= arm_d;
      found_q  <= found_d;
      any_q    <= any_d;
      ov_q     <= ov_d;
    end
  end

endmodule

[test/multi_timer_expiry_scheduler_top_test.sv]
module multi_timer_expiry_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = mtes_pkg::TIMER_SLOTS_DEF;
  localparam int unsigned IDB   = mtes_pkg::ID_BITS_DEF;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  mtes_pkg::in_word_t  in_word;
  logic                res_valid;
  mtes_pkg::out_word_t res_word;

  multi_timer_expiry_scheduler_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .in_i       (in_word),
    .res_valid_o(res_valid),
    .res_o      (res_word)
  );

  // scheduler shadow state
  logic [31:0] now_ms;
  logic [15:0] last_id;
  logic [31:0] ins_cnt;
  logic [31:0] sl_deadline [SLOTS];
  logic [15:0] sl_period   [SLOTS];
  logic [15:0] sl_id       [SLOTS];
  logic [31:0] sl_order    [SLOTS];
  logic        sl_pending  [SLOTS];
  logic        sl_armed    [SLOTS];

  mtes_pkg::out_word_t expected_words[$];
  int        errors;
  logic [15:0] issued_ids[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic void push_word(mtes_pkg::kind_e k, logic [15:0] id, logic [31:0] d,
                                    logic l);
    mtes_pkg::out_word_t w;
    w.kind = k;
    w.timer_id = id;
    w.next_delay_ms = d;
    w.last = l;
    expected_words.push_back(w);
  endfunction

  function automatic bit slot_due(int s);
    logic [31:0] d;
    d = sl_deadline[s] - now_ms;
    return d == 0 || d[31];
  endfunction

  function automatic bit served_first(int a, int b);
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] od;
    ka = (sl_deadline[a] - now_ms) ^ 32'h8000_0000;
    kb = (sl_deadline[b] - now_ms) ^ 32'h8000_0000;
    od = sl_order[a] - sl_order[b];
    if (ka != kb) return ka < kb;
    return od[31];
  endfunction

  function automatic void predict_tick();
    int pick;
    bit any;
    logic [31:0] best;
    logic [31:0] d;
    now_ms = now_ms + 1;
    for (int p = 0; p < SLOTS; p++) begin
      pick = -1;
      for (int s = 0; s < SLOTS; s++)
        if (sl_pending[s] && slot_due(s) && (pick < 0 || served_first(s, pick))) pick = s;
      if (pick < 0) break;
      if (!sl_armed[pick]) begin
        sl_pending[pick] = 1'b0;
      end else begin
        push_word(mtes_pkg::KIND_FIRED, sl_id[pick], 32'd0, 1'b0);
        if (sl_period[pick] != 0) begin
          sl_deadline[pick] = now_ms + 32'(sl_period[pick]);
          sl_order[pick] = ins_cnt;
          ins_cnt = ins_cnt + 1;
        end else begin
          sl_pending[pick] = 1'b0;
          sl_armed[pick] = 1'b0;
        end
      end
    end
    any = 0;
    best = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (sl_pending[s]) begin
        d = sl_deadline[s] - now_ms;
        if (!any || d < best) best = d;
        any = 1;
      end
    end
    push_word(mtes_pkg::KIND_SUMMARY, 16'd0, best, 1'b1);
  endfunction

  function automatic void predict_add(logic [15:0] dly, logic [15:0] per);
    int fs;
    logic [15:0] id;
    fs = -1;
    for (int s = 0; s < SLOTS; s++)
      if (!sl_pending[s]) begin
        fs = s;
        break;
      end
    if (fs < 0) begin
      push_word(mtes_pkg::KIND_FULL, 16'd0, 32'd0, 1'b1);
      return;
    end
    id = 16'((32'(last_id) + 1) & ((64'd1 << IDB) - 1));
    if (id == 0) id = 16'd1;
    last_id = id;
    sl_deadline[fs] = now_ms + 32'(dly);
    sl_period[fs] = per;
    sl_id[fs] = id;
    sl_order[fs] = ins_cnt;
    ins_cnt = ins_cnt + 1;
    sl_pending[fs] = 1'b1;
    sl_armed[fs] = 1'b1;
    issued_ids.push_back(id);
    if (issued_ids.size() > 32) void'(issued_ids.pop_front());
    push_word(mtes_pkg::KIND_ADD_OK, id, 32'd0, 1'b1);
  endfunction

  function automatic void predict_word(mtes_pkg::in_word_t w);
    case (w.mode)
      mtes_pkg::MODE_TICK:   predict_tick();
      mtes_pkg::MODE_ADD:    predict_add(w.delay_ms, w.period_ms);
      mtes_pkg::MODE_CANCEL: begin
        for (int s = 0; s < SLOTS; s++)
          if (sl_pending[s] && sl_armed[s] && sl_id[s] == w.cancel_id) sl_armed[s] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    mtes_pkg::out_word_t e;
    if (rst_n && res_valid) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word kind=%0d id=%0d", res_word.kind, res_word.timer_id);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (res_word.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, res_word.kind);
          errors++;
        end
        if (res_word.timer_id !== e.timer_id) begin
          $error("timer_id exp %0d got %0d", e.timer_id, res_word.timer_id);
          errors++;
        end
        if (res_word.next_delay_ms !== e.next_delay_ms) begin
          $error("next_delay_ms exp %0d got %0d", e.next_delay_ms, res_word.next_delay_ms);
          errors++;
        end
        if (res_word.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, res_word.last);
          errors++;
        end
      end
    end
  end

  int burst_left;

  task automatic send_word(logic [1:0] m, logic [15:0] dly, logic [15:0] per,
                           logic [15:0] cid);
    mtes_pkg::in_word_t w;
    int gap;
    w.mode = m;
    w.delay_ms = dly;
    w.period_ms = per;
    w.cancel_id = cid;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        start <= 1'b0;
        in_word <= mtes_pkg::in_word_t'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    predict_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    in_word <= mtes_pkg::in_word_t'($urandom);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_tick();
    send_word(mtes_pkg::MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_add(logic [15:0] dly, logic [15:0] per);
    send_word(mtes_pkg::MODE_ADD, dly, per, 16'($urandom));
  endtask

  task automatic send_cancel(logic [15:0] cid);
    send_word(mtes_pkg::MODE_CANCEL, 16'($urandom), 16'($urandom), cid);
  endtask

  task automatic test_directed();
    send_tick();
    send_add(16'd0, 16'd0);
    send_add(16'd0, 16'd1);
    send_add(16'd2, 16'd0);
    send_add(16'hFFFF, 16'hFFFF);
    send_add(16'd3, 16'd0);
    send_cancel(16'd5);
    send_cancel(16'd999);
    send_word(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (4) send_tick();
    drain();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SLOTS + 2; i++) send_add(16'($urandom_range(1, 8)), 16'd0);
    repeat (10) send_tick();
    drain();
  endtask

  task automatic test_random(int n);
    int r;
    logic [15:0] cid;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_tick();
      else if (r < 80) begin
        if ($urandom_range(0, 9) == 0) send_add(16'($urandom), 16'($urandom));
        else send_add(16'($urandom_range(0, 20)),
                      ($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 12))));
      end else if (r < 95) begin
        cid = (issued_ids.size() != 0 && $urandom_range(0, 3) != 0) ?
              issued_ids[$urandom_range(0, issued_ids.size() - 1)] : 16'($urandom);
        send_cancel(cid);
      end else send_word(2'd3, 16'($urandom), 16'($urandom), 16'($urandom));
      if (i == n / 2) drain();
    end
    drain();
  endtask

  task automatic test_add_tick_pairs();
    repeat (40) begin
      send_add(16'd0, 16'd0);
      send_tick();
    end
    drain();
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    now_ms = 0;
    last_id = 0;
    ins_cnt = 0;
    for (int s = 0; s < SLOTS; s++) begin
      sl_deadline[s] = 0;
      sl_period[s] = 0;
      sl_id[s] = 0;
      sl_order[s] = 0;
      sl_pending[s] = 0;
      sl_armed[s] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);
    test_directed();
    test_full_table();
    test_random(360);
    test_add_tick_pairs();
    drain();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mtes_pkg.sv
hw/rtl/multi_timer_expiry_scheduler_top.sv
test/multi_timer_expiry_scheduler_top_test.sv
